@@ sv/u8dec_pkg.sv @@
// Shared types and constants for the UTF-8 byte decoder.
// No dependencies; imported by utf8_byte_decoder_top.
package u8dec_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 2;

  localparam logic [CpW-1:0]   QMark     = CpW'(63);
  localparam logic [ByteW-1:0] ContMask  = 8'hC0;
  localparam logic [ByteW-1:0] ContPat   = 8'h80;
  localparam logic [ByteW-1:0] Lead2Mask = 8'hE0;
  localparam logic [ByteW-1:0] Lead2Pat  = 8'hC0;
  localparam logic [ByteW-1:0] Lead3Mask = 8'hF0;
  localparam logic [ByteW-1:0] Lead3Pat  = 8'hE0;
  localparam logic [ByteW-1:0] Lead4Mask = 8'hF8;
  localparam logic [ByteW-1:0] Lead4Pat  = 8'hF0;
  localparam logic [ByteW-1:0] PayMask   = 8'h3F;

  // Results caused by one byte: a run of replacement marks followed by
  // an optional final code point.
  typedef struct packed {
    logic [CountW-1:0] qmarks;
    logic              has_final;
    logic [CpW-1:0]    cp;
    logic              mal;
  } burst_t;

endpackage

@@ sv/utf8_byte_decoder_top.sv @@
// Streaming UTF-8 decoder: one byte in, zero to four code points out.
// The first result of a byte is offered the cycle after its transfer,
// or later when the byte waits in the skid register behind an unfinished burst.
// Throughput: one byte per cycle while the output runs unstalled and each byte
// gives at most one result; n held bytes of a broken sequence give n marks.
// Reset (rst_ni, asynchronous, active low) closes any open sequence and
// empties the skid and result registers.
module utf8_byte_decoder_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [u8dec_pkg::ByteW-1:0]    text_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [u8dec_pkg::CpW-1:0]      code_point_o,
  output logic                           malformed_o,
  output logic                           last_of_run_o
);
  import u8dec_pkg::*;

  // Skid register: catches a byte offered while the result register is busy
  // with a burst, so that the input stall is a plain flop.
  logic             skid_valid_q, skid_valid_d;
  logic [ByteW-1:0] skid_byte_q, skid_byte_d;

  // Decoder state: the open multi-byte sequence.
  logic [CpW-1:0]    partial_q, partial_d;
  logic [CountW-1:0] need_q, need_d;
  logic [CountW-1:0] held_q, held_d;

  // Result register, holding the burst still to be handed out.
  logic   burst_valid_q, burst_valid_d;
  burst_t burst_q, burst_d;

  logic             head_valid;
  logic [ByteW-1:0] head_byte;
  logic             in_xfer;
  logic             out_xfer;
  logic             burst_last;
  logic             burst_free;
  logic             consume;
  logic             has_results;
  burst_t           dec;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;

  // The skid byte, when present, is always older than anything on the port.
  assign head_valid = skid_valid_q || in_valid_i;
  assign head_byte  = skid_valid_q ? skid_byte_q : text_byte_i;

  // The current transfer is the last of its burst when no marks remain
  // beyond this one and no final code point follows.
  assign burst_last = (burst_q.qmarks == '0) ||
                      ((burst_q.qmarks == CountW'(1)) && !burst_q.has_final);
  assign burst_free = !burst_valid_q || (out_xfer && burst_last);

  // Byte decode against the open sequence. A continuation extends the
  // sequence; anything else first flushes the held bytes as marks and is
  // then treated as a fresh byte.
  always_comb begin
    dec       = '0;
    dec.cp    = QMark;
    partial_d = partial_q;
    need_d    = need_q;
    held_d    = held_q;
    if ((need_q != '0) && ((head_byte & ContMask) == ContPat)) begin
      partial_d = {partial_q[CpW-7:0], head_byte[5:0]};
      need_d    = need_q - CountW'(1);
      held_d    = held_q + CountW'(1);
      if (need_q == CountW'(1)) begin
        dec.has_final = 1'b1;
        dec.cp        = {partial_q[CpW-7:0], head_byte[5:0]};
        dec.mal       = 1'b0;
        partial_d     = '0;
        need_d        = '0;
        held_d        = '0;
      end
    end else begin
      dec.qmarks = (need_q != '0) ? held_q : '0;
      partial_d  = '0;
      need_d     = '0;
      held_d     = '0;
      priority if (head_byte == '0) begin
        // End of text: the flush above is all it causes.
      end else if (!head_byte[7]) begin
        dec.has_final = 1'b1;
        dec.cp        = CpW'(head_byte);
      end else if ((head_byte & Lead2Mask) == Lead2Pat) begin
        partial_d = CpW'(head_byte[4:0]);
        need_d    = CountW'(1);
        held_d    = CountW'(1);
      end else if ((head_byte & Lead3Mask) == Lead3Pat) begin
        partial_d = CpW'(head_byte[3:0]);
        need_d    = CountW'(2);
        held_d    = CountW'(1);
      end else if ((head_byte & Lead4Mask) == Lead4Pat) begin
        partial_d = CpW'(head_byte[2:0]);
        need_d    = CountW'(3);
        held_d    = CountW'(1);
      end else begin
        // Stray continuation or an invalid lead byte.
        dec.has_final = 1'b1;
        dec.cp        = QMark;
        dec.mal       = 1'b1;
      end
    end
  end

  assign has_results = (dec.qmarks != '0) || dec.has_final;

  // A byte that causes no result never waits for the result register.
  assign consume = head_valid && (!has_results || burst_free);

  always_comb begin
    skid_valid_d = skid_valid_q;
    skid_byte_d  = skid_byte_q;
    if (skid_valid_q && consume) begin
      skid_valid_d = 1'b0;
    end else if (in_xfer && !consume) begin
      skid_valid_d = 1'b1;
      skid_byte_d  = text_byte_i;
    end
  end

  always_comb begin
    burst_valid_d = burst_valid_q;
    burst_d       = burst_q;
    if (out_xfer) begin
      if (burst_last) begin
        burst_valid_d = 1'b0;
      end else begin
        burst_d.qmarks = burst_q.qmarks - CountW'(1);
      end
    end
    if (consume && has_results) begin
      burst_valid_d = 1'b1;
      burst_d       = dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q  <= 1'b0;
      burst_valid_q <= 1'b0;
      partial_q     <= '0;
      need_q        <= '0;
      held_q        <= '0;
    end else begin
      skid_valid_q  <= skid_valid_d;
      burst_valid_q <= burst_valid_d;
      if (consume) begin
        partial_q <= partial_d;
        need_q    <= need_d;
        held_q    <= held_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    skid_byte_q <= skid_byte_d;
    burst_q     <= burst_d;
  end

  assign in_stall_o    = skid_valid_q;
  assign out_valid_o   = burst_valid_q;
  assign code_point_o  = (burst_q.qmarks != '0) ? QMark : burst_q.cp;
  assign malformed_o   = (burst_q.qmarks != '0) ? 1'b1 : burst_q.mal;
  assign last_of_run_o = burst_last;

`ifndef ASSERT_OFF
  a_burst_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    burst_valid_q |-> ((burst_q.qmarks != '0) || burst_q.has_final))
    else $error("result register holds an empty burst");

  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !last_of_run_o) |=> out_valid_o)
    else $error("burst ended without a last_of_run result");

  a_open_seq_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (need_q != '0) |-> (held_q != '0))
    else $error("open sequence with no held bytes");

  a_mal_is_qmark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && malformed_o) |-> (code_point_o == QMark))
    else $error("malformed result is not a question mark");
`endif

endmodule
